// ----- design/block_delta_matcher_top_assert.svh -----
// Assertion macros used by the checker in bdm_checker.sv.
`ifndef BLOCK_DELTA_MATCHER_TOP_ASSERT_SVH
`define BLOCK_DELTA_MATCHER_TOP_ASSERT_SVH
`define BDM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BDM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- design/bdm_pkg.sv -----
package bdm_pkg;
	localparam int MaxSignatures = 256;
	localparam logic [16:0] AdlerMod = 17'd65521;
	localparam logic [31:0] CrcPoly = 32'hEDB88320;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic CFG_BLOCK_LENGTH = 1'b0;
	localparam logic CFG_DELTA_MODE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE,
		ST_SEARCH,
		ST_SEARCH_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic data;
		logic search_start;
		logic search_step;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic close;
		logic search_done;
	} stat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction
endpackage

// ----- design/bdm_ctrl.sv -----
module bdm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     command,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  bdm_pkg::stat_t stat,
	output bdm_pkg::ctrl_t ctrl
);
	import bdm_pkg::*;

	state_t state_q, state_d;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		acc = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				acc = in_valid;
				if (acc) begin
					unique case (cmd_t'(command))
						CMD_LOAD: ctrl.load = 1'b1;
						CMD_CLEAR: ctrl.clear = 1'b1;
						CMD_DATA: begin
							ctrl.data = 1'b1;
							state_d = ST_BYTE;
						end
						default: ;
					endcase
				end
			end
			ST_BYTE: begin
				if (stat.close) begin
					ctrl.search_start = 1'b1;
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SEARCH: begin
				ctrl.search_step = 1'b1;
				if (stat.search_done) begin
					state_d = ST_SEARCH_WAIT;
				end
			end
			ST_SEARCH_WAIT: begin
				ctrl.search_step = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					ctrl.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ----- design/bdm_datapath.sv -----
module bdm_datapath #(
	parameter int MAX_SIGNATURES = bdm_pkg::MaxSignatures
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bdm_pkg::ctrl_t ctrl,
	output bdm_pkg::stat_t stat,
	input  logic [16:0]    block_length_cfg,
	input  logic           delta_mode_cfg,
	input  logic [7:0]     data_byte,
	input  logic           end_of_file,
	input  logic [31:0]    sig_weak,
	input  logic [31:0]    sig_strong,
	input  logic [16:0]    sig_size,
	output logic [47:0]    block_offset,
	output logic [16:0]    block_bytes,
	output logic [31:0]    weak_sum,
	output logic [31:0]    strong_sum,
	output logic           matched,
	output logic           table_overflow
);
	import bdm_pkg::*;

	localparam int AW = (MAX_SIGNATURES > 1) ? $clog2(MAX_SIGNATURES) : 1;
	localparam int CW = $clog2(MAX_SIGNATURES + 1);
	localparam logic [CW-1:0] Full = CW'(MAX_SIGNATURES);

	logic [15:0] a_q, b_q;
	logic [31:0] crc_q;
	logic [16:0] cnt_q;
	logic        eof_q;
	logic [47:0] off_q;
	logic [31:0] seen_q;
	logic [CW-1:0] sigcnt_q;
	logic        ovf_q;
	logic [31:0] wmem [MAX_SIGNATURES];
	logic [31:0] smem [MAX_SIGNATURES];
	logic [16:0] zmem [MAX_SIGNATURES];
	logic [CW-1:0] idx_q;
	logic        rd_v_q;
	logic [31:0] rw_q, rs_q;
	logic [16:0] rz_q;
	logic        hit_q;

	logic [16:0] a_sum, a_next, b_sum, b_next;
	logic [16:0] eff_len;
	logic [31:0] adler_word;

	assign a_sum = {1'b0, a_q} + {9'd0, data_byte};
	assign a_next = (a_sum >= AdlerMod) ? a_sum - AdlerMod : a_sum;
	assign b_sum = {1'b0, b_q} + a_next;
	assign b_next = (b_sum >= AdlerMod) ? b_sum - AdlerMod : b_sum;
	assign eff_len = (block_length_cfg == 17'd0 || block_length_cfg > 17'd65536)
		? 17'd65536 : block_length_cfg;
	assign adler_word = {b_q, a_q};
	assign stat.close = eof_q || (cnt_q >= eff_len);
	assign stat.search_done = (idx_q + CW'(1) >= sigcnt_q) || (CW'(32'd0) == sigcnt_q);

	always_ff @(posedge clk) begin
		if (ctrl.load && sigcnt_q != Full) begin
			wmem[sigcnt_q[AW-1:0]] <= sig_weak;
			smem[sigcnt_q[AW-1:0]] <= sig_strong;
			zmem[sigcnt_q[AW-1:0]] <= sig_size;
		end
		rw_q <= wmem[idx_q[AW-1:0]];
		rs_q <= smem[idx_q[AW-1:0]];
		rz_q <= zmem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 16'd1;
			b_q <= 16'd0;
			crc_q <= '1;
			cnt_q <= '0;
			eof_q <= 1'b0;
			off_q <= '0;
			seen_q <= '0;
			sigcnt_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			rd_v_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				if (sigcnt_q != Full) begin
					sigcnt_q <= sigcnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (ctrl.clear) begin
				sigcnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (ctrl.data) begin
				a_q <= a_next[15:0];
				b_q <= b_next[15:0];
				crc_q <= crc_byte(crc_q, data_byte);
				cnt_q <= cnt_q + 17'd1;
				eof_q <= end_of_file;
			end
			if (ctrl.search_start) begin
				idx_q <= '0;
				rd_v_q <= 1'b0;
				hit_q <= 1'b0;
			end else if (ctrl.search_step) begin
				if (idx_q != Full) begin
					idx_q <= idx_q + CW'(1);
				end
				rd_v_q <= (idx_q < sigcnt_q);
				if (rd_v_q && rw_q == adler_word && rs_q == ~crc_q && rz_q == cnt_q) begin
					hit_q <= 1'b1;
				end
			end
			if (ctrl.finish) begin
				if (eof_q) begin
					off_q <= '0;
					seen_q <= '0;
				end else begin
					off_q <= off_q + {31'd0, cnt_q};
					if (seen_q != '1) begin
						seen_q <= seen_q + 32'd1;
					end
				end
				a_q <= 16'd1;
				b_q <= 16'd0;
				crc_q <= '1;
				cnt_q <= '0;
				eof_q <= 1'b0;
			end
		end
	end

	// The search reads one entry a cycle; the last compare lands in the cycle after the read.
	assign block_offset = off_q;
	assign block_bytes = cnt_q;
	assign weak_sum = adler_word;
	assign strong_sum = ~crc_q;
	assign matched = delta_mode_cfg && hit_q && ({{(32-CW){1'b0}}, sigcnt_q} > seen_q);
	assign table_overflow = ovf_q;
endmodule

// ----- design/block_delta_matcher_top.sv -----
// Channel   Valid       Stall       Payload
// input     in_valid    in_stall    command, data_byte, end_of_file, sig_weak/strong/size
// output    out_valid   out_stall   block_offset, block_bytes, weak_sum, strong_sum, matched,
//                                   table_overflow
// Loads and clears complete in ST_IDLE; a byte that does not close a block visits ST_BYTE.
// A closing byte adds one search step per loaded signature (at least one), then
// ST_SEARCH_WAIT for the last compare and ST_OUT, which presents the result.
// The search reads the signature memory through its single registered read port.
// arst_n resets counters, sums (to their start values) and the signature count; table contents are not cleared.
// While a result waits under out_stall no new request is taken.
module block_delta_matcher_top #(
	parameter int MAX_SIGNATURES = bdm_pkg::MaxSignatures
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	input  logic [31:0] sig_weak,
	input  logic [31:0] sig_strong,
	input  logic [16:0] sig_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [47:0] block_offset,
	output logic [16:0] block_bytes,
	output logic [31:0] weak_sum,
	output logic [31:0] strong_sum,
	output logic        matched,
	output logic        table_overflow
);
	import bdm_pkg::*;

	logic [16:0] block_length_q;
	logic        delta_mode_q;
	ctrl_t ctrl;
	stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= 17'd4096;
			delta_mode_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_LENGTH: block_length_q <= cfg_data;
				CFG_DELTA_MODE: delta_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bdm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .command, .in_stall, .out_valid, .out_stall,
		.stat, .ctrl
	);

	bdm_datapath #(.MAX_SIGNATURES(MAX_SIGNATURES)) u_dp (
		.clk, .arst_n, .ctrl, .stat,
		.block_length_cfg(block_length_q), .delta_mode_cfg(delta_mode_q),
		.data_byte, .end_of_file, .sig_weak, .sig_strong, .sig_size,
		.block_offset, .block_bytes, .weak_sum, .strong_sum, .matched, .table_overflow
	);
endmodule

// ----- design/bdm_checker.sv -----
module bdm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [16:0] block_bytes,
	input logic       table_overflow
);
`include "block_delta_matcher_top_assert.svh"

	`BDM_ASSERT_IMP(a_no_overlap, out_valid, in_stall)
	`BDM_ASSERT_IMP(a_size_nonzero, out_valid, block_bytes != 17'd0)
	`BDM_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(block_bytes))
	`BDM_ASSERT_NEXT(a_ovf_sticky, table_overflow && !(in_valid && !in_stall), table_overflow)
endmodule

bind block_delta_matcher_top bdm_checker u_chk (.*);
